FILE: rtl/core/ffve_pkg.sv
// ----------------------------------------------------------------------------
// ffve_pkg
// shared types, codes and the hex digit helper of the form field extractor
// ----------------------------------------------------------------------------
package ffve_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] HEX_TEN  = 8'd10;
  localparam logic [7:0] CASE_GAP = CH_LOW_A - CH_UP_A;
  localparam int         NIBBLE   = 4;

  localparam logic REG_KEY_TEXT   = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_EQUALS = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PCT_NONE = 2'd0,
    PCT_ONE  = 2'd1,
    PCT_TWO  = 2'd2
  } pct_t;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ABSENT = 2'd2,
    KIND_NO_EQ  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       fin;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] x;
    x = c;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      x = c + CASE_GAP;
    end
    return x - CH_LOW_A + HEX_TEN;
  endfunction

endpackage

FILE: rtl/core/ffve_if.sv
// ----------------------------------------------------------------------------
// ffve_if
// valid/ready channels for body bytes and extracted results
// ----------------------------------------------------------------------------
interface ffve_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_body;

  modport source (output valid, output data_byte, output end_of_body, input ready);
  modport sink (input valid, input data_byte, input end_of_body, output ready);
endinterface

interface ffve_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       final_mark;

  modport source (output valid, output out_byte, output kind, output final_mark, input ready);
  modport sink (input valid, input out_byte, input kind, input final_mark, output ready);
endinterface

FILE: rtl/core/ffve_res_fifo.sv
// ----------------------------------------------------------------------------
// ffve_res_fifo
// four entry result queue, takes up to two results per cycle, gives one per cycle while the sink is ready
// ----------------------------------------------------------------------------
module ffve_res_fifo
  import ffve_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space_ok,
  ffve_result_if.source result
);

  res_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  res_t       head;

  assign pop      = result.valid && result.ready;
  assign space_ok = (count <= 3'd2);
  assign head     = mem[rd_ptr];

  assign result.valid      = (count != 3'd0);
  assign result.out_byte   = head.data;
  assign result.kind       = head.kind;
  assign result.final_mark = head.fin;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push.n} - {2'b00, pop};
    end
  end

endmodule

FILE: rtl/core/ffve_core.sv
// ----------------------------------------------------------------------------
// ffve_core
// input register, key search and value decode state, per byte step logic
// ----------------------------------------------------------------------------
module ffve_core
  import ffve_pkg::*;
#(
  parameter int VALUE_LIMIT = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  ffve_body_if.sink   body,
  input  logic        space_ok,
  output push_t       push
);

  localparam int CW = $clog2(VALUE_LIMIT + 1);
  localparam int SW = $clog2(KEY_BYTES + 1);

  typedef struct packed {
    logic [KEY_BYTES-1:0][7:0] recent;
    logic [SW-1:0]             seen;
    phase_t                    phase;
    pct_t                      pct;
    logic [7:0]                fhc;
    logic [CW-1:0]             cnt;
  } state_t;

  typedef struct packed {
    state_t     s;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

  logic [63:0] key_text;
  logic [3:0]  key_length;
  logic [3:0]  klen;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        fire;
  state_t      st;
  state_t      st_next;
  step_t       x0;
  step_t       x1;
  step_t       x2;

  function automatic step_t put(input step_t x, input logic [7:0] b, input kind_t k,
                                input logic f);
    res_t r;
    r.data = b;
    r.kind = k;
    r.fin  = f;
    if (x.n == 2'd0) begin
      x.r0 = r;
    end else if (x.n == 2'd1) begin
      x.r1 = r;
    end
    if (x.n != 2'd2) begin
      x.n = x.n + 2'd1;
    end
    return x;
  endfunction

  function automatic step_t finish(input step_t x, input kind_t k);
    x = put(x, CH_NUL, k, 1'b1);
    x.s.phase = PH_DONE;
    x.s.pct   = PCT_NONE;
    return x;
  endfunction

  function automatic step_t emit(input step_t x, input logic [7:0] v);
    x = put(x, v, KIND_VALUE, 1'b0);
    x.s.cnt = x.s.cnt + 1'b1;
    if (x.s.cnt == CW'(VALUE_LIMIT)) begin
      x = finish(x, KIND_DONE);
    end
    return x;
  endfunction

  function automatic step_t plain(input step_t x, input logic [7:0] c);
    if (c == CH_NUL || c == CH_AMP) begin
      x = finish(x, KIND_DONE);
    end else if (c == CH_PCT) begin
      x.s.pct = PCT_ONE;
    end else if (c == CH_PLUS) begin
      x = emit(x, CH_SPACE);
    end else begin
      x = emit(x, c);
    end
    return x;
  endfunction

  function automatic step_t value(input step_t x, input logic [7:0] c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = hex_val(x.s.fhc);
    lo = hex_val(c);
    case (x.s.pct)
      PCT_ONE: begin
        if (c == CH_NUL) begin
          x = finish(x, KIND_DONE);
        end else begin
          x.s.fhc = c;
          x.s.pct = PCT_TWO;
        end
      end
      PCT_TWO: begin
        x.s.pct = PCT_NONE;
        if (c == CH_NUL) begin
          x = plain(x, x.s.fhc);
          if (x.s.phase != PH_DONE) begin
            x = finish(x, KIND_DONE);
          end
        end else begin
          x = emit(x, (hi << NIBBLE) | lo);
        end
      end
      default: begin
        x.s.pct = PCT_NONE;
        x = plain(x, c);
      end
    endcase
    return x;
  endfunction

  function automatic step_t process(input step_t x, input logic [7:0] c, input logic [3:0] kl,
                                    input logic [63:0] key);
    logic       match;
    logic [2:0] kidx;
    if (x.s.phase == PH_SEARCH && kl == 4'd0 && x.s.seen == '0) begin
      x.s.phase = PH_EQUALS;
    end
    case (x.s.phase)
      PH_SEARCH: begin
        if (c == CH_NUL) begin
          x = finish(x, KIND_ABSENT);
        end else begin
          for (int i = KEY_BYTES - 1; i > 0; i--) begin
            x.s.recent[i] = x.s.recent[i-1];
          end
          x.s.recent[0] = c;
          if (x.s.seen != SW'(KEY_BYTES)) begin
            x.s.seen = x.s.seen + 1'b1;
          end
          match = (4'(x.s.seen) >= kl);
          for (int p = 0; p < KEY_BYTES; p++) begin
            kidx = 3'(kl - 4'(p) - 4'd1);
            if (4'(p) < kl && x.s.recent[p] != key[8*kidx +: 8]) begin
              match = 1'b0;
            end
          end
          if (match) begin
            x.s.phase = PH_EQUALS;
          end
        end
      end
      PH_EQUALS: begin
        if (c == CH_EQ) begin
          x.s.phase = PH_VALUE;
          x.s.cnt   = '0;
        end else begin
          x = finish(x, KIND_NO_EQ);
        end
      end
      PH_VALUE: begin
        x = value(x, c);
      end
      default: begin
      end
    endcase
    return x;
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text   <= '0;
      key_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_TEXT:   key_text   <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign klen       = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
  assign fire       = in_full && space_ok;
  assign body.ready = !in_full || fire;

  // input register
  always_ff @(posedge clk) begin
    if (body.valid && body.ready) begin
      in_byte <= body.data_byte;
      in_last <= body.end_of_body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (body.valid && body.ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  // body end acts as a trailing nul, then the state clears
  always_comb begin
    x0    = '0;
    x0.s  = st;
    x1    = process(x0, in_byte, klen, key_text);
    x2    = x1;
    if (in_last && x1.s.phase != PH_DONE) begin
      x2 = process(x1, CH_NUL, klen, key_text);
    end
    st_next = in_last ? state_t'('0) : x2.s;
    push    = '0;
    if (fire) begin
      push.n  = x2.n;
      push.r0 = x2.r0;
      push.r1 = x2.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

FILE: rtl/core/form_field_value_extractor_top.sv
// ----------------------------------------------------------------------------
// form_field_value_extractor_top
// finds a configured key in a form-encoded body and streams its decoded value
// ----------------------------------------------------------------------------
// path: a byte is held in the input register until the queue has room, then its results enter the queue
// throughput: one body byte per cycle while the queue has room; bytes that yield two
//   results fill the four entry queue faster than its single-result output port drains it
// reset: synchronous rst clears the key registers, search state and queue
// ----------------------------------------------------------------------------
module form_field_value_extractor_top
  import ffve_pkg::*;
#(
  parameter int VALUE_LIMIT = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [63:0]    cfg_data,
  ffve_body_if.sink      body,
  ffve_result_if.source  result
);

  push_t push;
  logic  space_ok;

  ffve_core #(
    .VALUE_LIMIT (VALUE_LIMIT),
    .KEY_BYTES   (KEY_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .body      (body),
    .space_ok  (space_ok),
    .push      (push)
  );

  ffve_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .result   (result)
  );

endmodule
